@@ rtl/core/rlw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlw_pkg
// Shared types, codes and constants of the recursive lock with watchdog.
// ----------------------------------------------------------------------------
package rlw_pkg;

	localparam int unsigned DEPTH_W   = 8;
	localparam int unsigned COUNT_W   = 32;
	localparam int unsigned STAMP_W   = 64;
	localparam int unsigned LIMIT_W   = 48;

	localparam int unsigned DEPTH_MAX_DEFAULT = 255;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64'd2000000 * 64'd3000);

	// Operation codes of an input item.
	typedef enum logic {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_FRESH   = 3'd0,
		ST_RECURSE = 3'd1,
		ST_BUSY    = 3'd2,
		ST_FULL    = 3'd3,
		ST_NESTED  = 3'd4,
		ST_FREED   = 3'd5,
		ST_RELERR  = 3'd6
	} status_t;

	// One result item.
	typedef struct packed {
		logic                granted;
		status_t             status;
		logic                owner_cpu;
		logic                lock_held;
		logic [DEPTH_W-1:0]  lock_depth;
		logic                watchdog_alarm;
		logic                engaged_event;
		logic [COUNT_W-1:0]  acquisitions;
		logic [COUNT_W-1:0]  contentions;
	} result_t;

	// Saturating increment of a counter.
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/recursive_lock_with_watchdog.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// recursive_lock_with_watchdog
// Two-CPU recursive lock with spin watchdog and per-CPU counters.
// ----------------------------------------------------------------------------
// Each request is registered, evaluated against the lock state and its result
// registered; a result is presented on the output from the result register. One
// request is accepted every cycle while the input does not stall. The only limit on
// throughput is the output register: while a result waits and the request
// register is full, the input stalls. The watchdog limit may be written at
// any time the block is idle; the configuration port is always ready.
module recursive_lock_with_watchdog import rlw_pkg::*; #(
	parameter int unsigned DEPTH_MAX = DEPTH_MAX_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                operation,
	input  wire logic                cpu,
	input  wire logic [STAMP_W-1:0]  now,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     granted,
	output logic [2:0]               status,
	output logic                     owner_cpu,
	output logic                     lock_held,
	output logic [DEPTH_W-1:0]       lock_depth,
	output logic                     watchdog_alarm,
	output logic                     engaged_event,
	output logic [COUNT_W-1:0]       acquisitions,
	output logic [COUNT_W-1:0]       contentions,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [LIMIT_W-1:0]  cfg_data
);

	logic                valid_s1;
	op_t                 op_s1;
	logic                cpu_s1;
	logic [STAMP_W-1:0]  now_s1;
	logic                out_valid_q;
	result_t             res_q;
	result_t             res;
	logic [LIMIT_W-1:0]  limit_q;
	logic                advance, fire, take;

	// Handshake control.
	assign advance   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign take      = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Watchdog limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= op_t'(operation);
			cpu_s1 <= cpu;
			now_s1 <= now;
		end
	end

	rlw_engine #(
		.DEPTH_MAX(DEPTH_MAX)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.op    (op_s1),
		.cpu   (cpu_s1),
		.now   (now_s1),
		.limit (limit_q),
		.res   (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	// Result fields.
	assign out_valid      = out_valid_q;
	assign granted        = res_q.granted;
	assign status         = res_q.status;
	assign owner_cpu      = res_q.owner_cpu;
	assign lock_held      = res_q.lock_held;
	assign lock_depth     = res_q.lock_depth;
	assign watchdog_alarm = res_q.watchdog_alarm;
	assign engaged_event  = res_q.engaged_event;
	assign acquisitions   = res_q.acquisitions;
	assign contentions    = res_q.contentions;

	// The input stalls only behind a full request register and a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a held result");

	// A request that is not evaluated stays in its register.
	a_request_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(now_s1))
		else $error("waiting request was lost");

endmodule
`default_nettype wire

@@ rtl/core/rlw_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlw_engine
// Lock state and its combinational update for one request.
// ----------------------------------------------------------------------------
module rlw_engine import rlw_pkg::*; #(
	parameter int unsigned DEPTH_MAX = DEPTH_MAX_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire op_t                 op,
	input  wire logic                cpu,
	input  wire logic [STAMP_W-1:0]  now,
	input  wire logic [LIMIT_W-1:0]  limit,
	output result_t                  res
);

	localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(DEPTH_MAX);

	logic                held_q, owner_q, alarm_fired_q, seen_q;
	logic [DEPTH_W-1:0]  rec_q;
	logic [COUNT_W-1:0]  acq_q [2];
	logic [COUNT_W-1:0]  cont_q [2];
	logic                spin_q [2];
	logic [STAMP_W-1:0]  start_q [2];

	logic                held_d, owner_d, alarm_fired_d, seen_d;
	logic [DEPTH_W-1:0]  rec_d;
	logic [COUNT_W-1:0]  acq_d [2];
	logic [COUNT_W-1:0]  cont_d [2];
	logic                spin_d [2];
	logic [STAMP_W-1:0]  start_d [2];
	status_t             status;
	logic                alarm, engaged;
	logic [STAMP_W-1:0]  spin_base, elapsed;

	// Spin time of the requester; a first refusal measures from now.
	assign spin_base = spin_q[cpu] ? start_q[cpu] : now;
	assign elapsed   = now - spin_base;

	// Next state for the request.
	always_comb begin
		held_d        = held_q;
		owner_d       = owner_q;
		rec_d         = rec_q;
		acq_d         = acq_q;
		cont_d        = cont_q;
		spin_d        = spin_q;
		start_d       = start_q;
		alarm_fired_d = alarm_fired_q;
		seen_d        = seen_q;
		alarm         = 1'b0;
		engaged       = 1'b0;
		status        = ST_RELERR;
		case (op)
			OP_ACQUIRE: begin
				if (held_q && owner_q == cpu) begin
					if (rec_q >= DEPTH_TOP) begin
						status = ST_FULL;
					end else begin
						rec_d  = rec_q + DEPTH_W'(1);
						status = ST_RECURSE;
					end
				end else if (!held_q) begin
					held_d      = 1'b1;
					owner_d     = cpu;
					rec_d       = DEPTH_W'(1);
					acq_d[cpu]  = sat_inc(acq_q[cpu]);
					if (spin_q[cpu]) begin
						cont_d[cpu] = sat_inc(cont_q[cpu]);
					end
					spin_d[cpu] = 1'b0;
					// The requester's count is nonzero now; the other decides.
					if (!seen_q && acq_q[~cpu] != '0) begin
						seen_d  = 1'b1;
						engaged = 1'b1;
					end
					status = ST_FRESH;
				end else begin
					spin_d[cpu]  = 1'b1;
					start_d[cpu] = spin_base;
					if (!alarm_fired_q && elapsed >= {{(STAMP_W-LIMIT_W){1'b0}}, limit}) begin
						alarm_fired_d = 1'b1;
						alarm         = 1'b1;
					end
					status = ST_BUSY;
				end
			end
			OP_RELEASE: begin
				if (!held_q || owner_q != cpu || rec_q == '0) begin
					status = ST_RELERR;
				end else begin
					rec_d = rec_q - DEPTH_W'(1);
					if (rec_q == DEPTH_W'(1)) begin
						held_d  = 1'b0;
						owner_d = 1'b0;
						status  = ST_FREED;
					end else begin
						status = ST_NESTED;
					end
				end
			end
			default: begin
				status = ST_RELERR;
			end
		endcase
	end

	// Result as seen after the request.
	always_comb begin
		res.granted        = held_d && (owner_d == cpu);
		res.status         = status;
		res.owner_cpu      = held_d ? owner_d : 1'b0;
		res.lock_held      = held_d;
		res.lock_depth     = rec_d;
		res.watchdog_alarm = alarm;
		res.engaged_event  = engaged;
		res.acquisitions   = acq_d[cpu];
		res.contentions    = cont_d[cpu];
	end

	// Lock state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q        <= 1'b0;
			owner_q       <= 1'b0;
			rec_q         <= '0;
			acq_q         <= '{default: '0};
			cont_q        <= '{default: '0};
			spin_q        <= '{default: 1'b0};
			start_q       <= '{default: '0};
			alarm_fired_q <= 1'b0;
			seen_q        <= 1'b0;
		end else if (fire) begin
			held_q        <= held_d;
			owner_q       <= owner_d;
			rec_q         <= rec_d;
			acq_q         <= acq_d;
			cont_q        <= cont_d;
			spin_q        <= spin_d;
			start_q       <= start_d;
			alarm_fired_q <= alarm_fired_d;
			seen_q        <= seen_d;
		end
	end

	// The lock is held exactly while its depth is nonzero.
	a_held_depth: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == (rec_q != '0))
		else $error("lock held flag and depth disagree");

	// The alarm pulses only before it has ever fired.
	a_alarm_once: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.watchdog_alarm |=> alarm_fired_q && $rose(alarm_fired_q))
		else $error("watchdog alarm fired more than once");

	// The engaged flag rises only on a fresh grant.
	a_engaged_grant: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(seen_q) |-> $past(fire && op == OP_ACQUIRE && !held_q))
		else $error("engaged flag rose outside a fresh grant");

endmodule
`default_nettype wire
